>>> rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants for the servo PWM record and playback block.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Circular pulse store.
    localparam int STORE_DEPTH = 100;
    localparam int PTR_W       = $clog2(STORE_DEPTH);

    // Field and register widths.
    localparam int ADC_W    = 12;
    localparam int PULSE_W  = 13;
    localparam int MIN_W    = 12;
    localparam int SPAN_W   = 12;
    localparam int PERIOD_W = 16;
    localparam int REC_W    = 20;
    localparam int PROD_W   = ADC_W + SPAN_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SPAN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_INTERVAL = 2'd3;

    // Reset values.
    localparam logic [MIN_W-1:0]    RST_PULSE_MIN       = 12'd1000;
    localparam logic [SPAN_W-1:0]   RST_PULSE_SPAN      = 12'd1000;
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD      = 16'd20000;
    localparam logic [REC_W-1:0]    RST_RECORD_INTERVAL = 20'd100000;
    localparam logic [PULSE_W-1:0]  RST_PULSE           = 13'd1500;

    // Full-scale ADC code used as the divisor of the mapping.
    localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

endpackage

>>> rtl/servo_pwm_record_playback.sv
// ----------------------------------------------------------------------------
// servo_pwm_record_playback
// Servo PWM generator that records potentiometer positions and plays them back.
// ----------------------------------------------------------------------------
// Every request on the input stream is one timer tick and yields exactly one
// result on the output stream, in order. The block takes one request per
// clock cycle unless a result held on the output stream stalls it. The edge
// that takes a request loads the first of the three stages that map the ADC
// sample: one multiply stage, one reciprocal stage for the division by 4095,
// and one correction stage, from which the tick moves through the state update
// into the output register. The period, record and pointer state, and the
// pulse store RAM, are updated once per tick as the tick leaves the mapping
// pipeline. The RAM is read ahead at the next read pointer, with the write of
// the same cycle forwarded. Store entries carry valid bits that reset clears
// at once, so an entry never written reads as zero and no clearing pass
// follows reset. The user must write configuration registers only while no
// tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module servo_pwm_record_playback
    import spm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Input ticks. tdata: [0] adc_valid, [12:1] adc_value, [13] toggle,
    // [15:14] zero.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,

    // Results. tdata: [0] servo_out, [1] playback_mode, [14:2] pulse_width,
    // [15] zero.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,

    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [MIN_W-1:0]    r_pulse_min;
    logic [SPAN_W-1:0]   r_pulse_span;
    logic [PERIOD_W-1:0] r_pwm_period;
    logic [REC_W-1:0]    r_record_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min       <= RST_PULSE_MIN;
            r_pulse_span      <= RST_PULSE_SPAN;
            r_pwm_period      <= RST_PWM_PERIOD;
            r_record_interval <= RST_RECORD_INTERVAL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PULSE_MIN:       r_pulse_min       <= i_cfg_data[MIN_W-1:0];
                CFG_PULSE_SPAN:      r_pulse_span      <= i_cfg_data[SPAN_W-1:0];
                CFG_PWM_PERIOD:      r_pwm_period      <= i_cfg_data[PERIOD_W-1:0];
                CFG_RECORD_INTERVAL: r_record_interval <= i_cfg_data[REC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A period or interval of zero behaves like one.
    logic [PERIOD_W-1:0] period_lim;
    logic [REC_W-1:0]    interval_lim;

    assign period_lim   = (r_pwm_period == '0) ? PERIOD_W'(1) : r_pwm_period;
    assign interval_lim = (r_record_interval == '0) ? REC_W'(1) : r_record_interval;

    // ------------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it loads, so bubbles collapse and a result waiting in the
    // output register does not stop earlier stages from filling.
    // ------------------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_c_vld, r_out_vld;
    logic en_a, en_b, en_c, en_out, step;

    assign en_out = !r_out_vld || i_m_axis_tready;
    assign en_c   = !r_c_vld || en_out;
    assign en_b   = !r_b_vld || en_c;
    assign en_a   = !r_a_vld || en_b;
    assign step   = r_c_vld && en_out;

    assign o_s_axis_tready = en_a;

    // Input field unpacking.
    logic             in_adc_valid;
    logic [ADC_W-1:0] in_adc_value;
    logic             in_toggle;

    assign in_adc_valid = i_s_axis_tdata[0];
    assign in_adc_value = i_s_axis_tdata[ADC_W:1];
    assign in_toggle    = i_s_axis_tdata[ADC_W+1];

    // ------------------------------------------------------------------------
    // Mapping pipeline: pulse = min + adc * span / 4095.
    // Stage A holds the product. Stage B holds an estimate of the quotient
    // from (p + p/4096) / 4096, which is never high and at most one low.
    // Stage C corrects the estimate with one compare and adds the minimum.
    // ------------------------------------------------------------------------
    logic              r_a_adcv, r_a_tog;
    logic [PROD_W-1:0] r_a_prod;
    logic              r_b_adcv, r_b_tog;
    logic [PROD_W-1:0] r_b_prod;
    logic [ADC_W-1:0]  r_b_quo;
    logic              r_c_adcv, r_c_tog;
    logic [PULSE_W-1:0] r_c_map;

    logic [PROD_W:0]    quo_sum;
    logic [ADC_W-1:0]   quo_est;
    logic [PROD_W:0]    quo_rem;
    logic [ADC_W-1:0]   quo_fix;
    logic [PULSE_W-1:0] map_val;

    assign quo_sum = {1'b0, r_a_prod} + (PROD_W+1)'(r_a_prod >> 12);
    assign quo_est = quo_sum[ADC_W+12-1:12];

    // Remainder p - q * 4095 = p - q * 4096 + q.
    assign quo_rem = {1'b0, r_b_prod} - ((PROD_W+1)'(r_b_quo) << 12)
                   + (PROD_W+1)'(r_b_quo);
    assign quo_fix = (quo_rem >= (PROD_W+1)'(ADC_FULL)) ? r_b_quo + ADC_W'(1) : r_b_quo;
    assign map_val = PULSE_W'(r_pulse_min) + PULSE_W'(quo_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_s_axis_tvalid;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (en_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_adcv <= in_adc_valid;
            r_a_tog  <= in_toggle;
            r_a_prod <= PROD_W'(in_adc_value) * PROD_W'(r_pulse_span);
        end
        if (en_b) begin
            r_b_adcv <= r_a_adcv;
            r_b_tog  <= r_a_tog;
            r_b_prod <= r_a_prod;
            r_b_quo  <= quo_est;
        end
        if (en_c) begin
            r_c_adcv <= r_b_adcv;
            r_c_tog  <= r_b_tog;
            r_c_map  <= map_val;
        end
    end

    // ------------------------------------------------------------------------
    // Tick state and the pulse store
    // ------------------------------------------------------------------------
    logic [PERIOD_W-1:0]    r_period_cnt, n_period_cnt;
    logic [REC_W-1:0]       r_record_cnt, n_record_cnt;
    logic [PULSE_W-1:0]     r_mapped, n_mapped;
    logic [PULSE_W-1:0]     r_compare, n_compare;
    logic                   r_pin, n_pin;
    logic                   r_mode, n_mode;
    logic [PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [STORE_DEPTH-1:0] r_valid, n_valid;

    // Read-ahead bookkeeping for the entry at the read pointer.
    logic               r_fwd_hit;
    logic [PULSE_W-1:0] r_fwd_data;
    logic               r_fwd_vld;

    logic               st_we;
    logic [PULSE_W-1:0] ram_q;
    logic [PULSE_W-1:0] fetched;
    logic [PERIOD_W:0]  period_inc;
    logic [REC_W-1:0]   record_inc;

    spm_ram #(
        .WIDTH (PULSE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (n_mapped),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_q)
    );

    // Contents of the entry at the current read pointer, including every
    // write made by earlier ticks.
    assign fetched = r_fwd_hit ? r_fwd_data : (r_fwd_vld ? ram_q : '0);

    assign period_inc = {1'b0, r_period_cnt} + (PERIOD_W+1)'(1);
    assign record_inc = r_record_cnt + REC_W'(1);

    always_comb begin
        n_period_cnt = r_period_cnt;
        n_record_cnt = r_record_cnt;
        n_mapped     = r_mapped;
        n_compare    = r_compare;
        n_pin        = r_pin;
        n_mode       = r_mode;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_valid      = r_valid;
        st_we        = 1'b0;

        if (step) begin
            // The toggle is applied first, then the sample in manual mode.
            n_mode = r_mode ^ r_c_tog;
            if (!n_mode && r_c_adcv) begin
                n_mapped  = r_c_map;
                n_compare = r_c_map;
            end

            // Period start raises the pin and, in playback, loads the next
            // stored width.
            if (r_period_cnt == '0) begin
                n_pin = 1'b1;
                if (n_mode) begin
                    n_compare = fetched;
                    n_rd_ptr  = (r_rd_ptr == PTR_W'(STORE_DEPTH - 1))
                              ? '0 : r_rd_ptr + PTR_W'(1);
                end
            end
            // The fall wins over the rise when both land on one tick.
            if (PULSE_W'(r_period_cnt) == n_compare
                && r_period_cnt[PERIOD_W-1:PULSE_W] == '0) begin
                n_pin = 1'b0;
            end

            n_period_cnt = (period_inc >= {1'b0, period_lim}) ? '0
                         : period_inc[PERIOD_W-1:0];

            // The record counter runs in both modes; only manual mode writes.
            n_record_cnt = record_inc;
            if (record_inc >= interval_lim) begin
                n_record_cnt = '0;
                if (!n_mode) begin
                    st_we             = 1'b1;
                    n_valid[r_wr_ptr] = 1'b1;
                    n_wr_ptr          = (r_wr_ptr == PTR_W'(STORE_DEPTH - 1))
                                      ? '0 : r_wr_ptr + PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_cnt <= '0;
            r_record_cnt <= '0;
            r_mapped     <= RST_PULSE;
            r_compare    <= RST_PULSE;
            r_pin        <= 1'b0;
            r_mode       <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_valid      <= '0;
            r_fwd_hit    <= 1'b0;
            r_fwd_vld    <= 1'b0;
        end else begin
            r_period_cnt <= n_period_cnt;
            r_record_cnt <= n_record_cnt;
            r_mapped     <= n_mapped;
            r_compare    <= n_compare;
            r_pin        <= n_pin;
            r_mode       <= n_mode;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_valid      <= n_valid;
            // The RAM returns old data when read and write meet, so the write
            // is forwarded; the valid bit is sampled before this write too.
            r_fwd_hit    <= st_we && (r_wr_ptr == n_rd_ptr);
            r_fwd_vld    <= r_valid[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= n_mapped;
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [M_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {1'b0, n_compare, n_mode, n_pin};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> rtl/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
